FILE: design/lrexp_pkg.sv
// ----------------------------------------------------------------------------
// lrexp_pkg
// Shared constants and types of the left-to-right expression evaluator:
// character codes, result status codes and the request to the iterative unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lrexp_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned STATUS_BITS   = 2;

  // character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // result status
  localparam logic [STATUS_BITS-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_BAD  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_DIV0 = 2'd2;

  typedef enum logic [0:0] {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

`default_nettype wire

FILE: design/lrexp_if.sv
// ----------------------------------------------------------------------------
// lrexp channel interfaces
// Valid/ready channels for characters in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrexp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_expression;

  modport source (output valid, output char_code, output end_of_expression, input ready);
  modport sink   (input valid, input char_code, input end_of_expression, output ready);
endinterface

interface lrexp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

FILE: design/left_to_right_expression_evaluator_core.sv
// ----------------------------------------------------------------------------
// left_to_right_expression_evaluator_core
// Evaluates an ASCII expression one character per transfer, left to right,
// with no operator precedence, and returns one value and status per expression.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | transfer
//  in_i    | in  | char_code[7:0], end_of_expression | valid & ready
//  out_o   | out | value[31:0] signed, status[1:0]   | valid & ready
//
//  A number completed after * (or after / with a nonzero divisor) is passed to
//  the bit-serial multiply/divide unit, and input waits until that unit is done.
//  The last character of an expression leads to the emit state, which loads the result.
//  Reset returns the evaluator to the start of an expression.
//  A result waiting on out_o does not block input; only the next result stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module left_to_right_expression_evaluator_core #(
  parameter int unsigned WORD_BITS = lrexp_pkg::WORD_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lrexp_in_if.sink   in_i,
  lrexp_out_if.source out_o
);
  import lrexp_pkg::*;

  localparam int unsigned WB = WORD_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    TOK_NONE,
    TOK_NUM,
    TOK_ADD,
    TOK_SUB,
    TOK_MUL,
    TOK_DIV
  } tok_e;

  state_e                 state_q, state_d;
  logic [WB-1:0]          acc_q, acc_d;
  logic                   digits_q, digits_d;
  tok_e                   tok_q, tok_d;
  logic [WB-1:0]          run_q, run_d;
  logic                   bad_q, bad_d;
  logic                   divz_q, divz_d;
  logic                   pend_end_q, pend_end_d;
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0]  out_value_q, out_value_d;
  logic [STATUS_BITS-1:0] out_status_q, out_status_d;

  alu_req_t               alu_req;
  logic                   alu_done;
  logic [WB-1:0]          alu_res;

  logic                   in_xfer;
  logic [7:0]             c;
  logic                   is_digit, is_space, is_op, active;
  logic [WB-1:0]          acc_x10, acc_eff;
  logic                   dig_eff, bad_eff, cmpl;
  tok_e                   op_tok;
  logic [VALUE_BITS+WB-1:0] run_ext;

  lrexp_alu #(
    .WORD_BITS (WORD_BITS)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (run_q),
    .b_i      (acc_eff),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  assign in_i.ready   = (state_q == ST_IDLE);
  assign in_xfer      = in_i.valid && in_i.ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.value  = out_value_q;
  assign out_o.status = out_status_q;

  assign c        = in_i.char_code;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_space = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  assign is_op    = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  assign active   = !bad_q;

  always_comb begin
    case (c)
      CH_PLUS:  op_tok = TOK_ADD;
      CH_MINUS: op_tok = TOK_SUB;
      CH_STAR:  op_tok = TOK_MUL;
      default:  op_tok = TOK_DIV;
    endcase
  end

  // accumulator times ten plus the new digit, wrapping at the word width
  assign acc_x10 = {acc_q[WB-4:0], 3'b000} + {acc_q[WB-2:0], 1'b0};
  assign acc_eff = (active && is_digit) ? (acc_x10 + WB'(c[3:0])) : acc_q;
  assign dig_eff = digits_q || (active && is_digit);
  assign bad_eff = bad_q || (active && !is_digit && !is_space && !is_op);
  assign cmpl    = !bad_eff && dig_eff && (is_space || is_op || in_i.end_of_expression);
  assign run_ext = {{VALUE_BITS{1'b0}}, run_q};

  always_comb begin
    state_d      = state_q;
    acc_d        = acc_q;
    digits_d     = digits_q;
    tok_d        = tok_q;
    run_d        = run_q;
    bad_d        = bad_q;
    divz_d       = divz_q;
    pend_end_d   = pend_end_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    alu_req      = '{start: 1'b0, op: ALU_MUL};

    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          acc_d    = acc_eff;
          digits_d = dig_eff;
          bad_d    = bad_eff;
          if (cmpl) begin
            acc_d    = '0;
            digits_d = 1'b0;
            tok_d    = TOK_NUM;
            if (!divz_q) begin
              case (tok_q)
                TOK_NONE: run_d = acc_eff;
                TOK_ADD:  run_d = run_q + acc_eff;
                TOK_SUB:  run_d = run_q - acc_eff;
                TOK_MUL:  alu_req = '{start: 1'b1, op: ALU_MUL};
                TOK_DIV: begin
                  if (acc_eff == '0) begin
                    divz_d = 1'b1;
                  end else begin
                    alu_req = '{start: 1'b1, op: ALU_DIV};
                  end
                end
                default: ;
              endcase
            end
          end
          if (active && is_op) begin
            tok_d = op_tok;
          end
          pend_end_d = in_i.end_of_expression;
          if (alu_req.start) begin
            state_d = ST_EXEC;
          end else if (in_i.end_of_expression) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EXEC: begin
        if (alu_done) begin
          run_d   = alu_res;
          state_d = pend_end_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          if (bad_q) begin
            out_status_d = STAT_BAD;
            out_value_d  = '0;
          end else if (divz_q) begin
            out_status_d = STAT_DIV0;
            out_value_d  = '0;
          end else begin
            out_status_d = STAT_OK;
            out_value_d  = run_ext[VALUE_BITS-1:0];
          end
          acc_d      = '0;
          digits_d   = 1'b0;
          tok_d      = TOK_NONE;
          run_d      = '0;
          bad_d      = 1'b0;
          divz_d     = 1'b0;
          pend_end_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      acc_q        <= '0;
      digits_q     <= 1'b0;
      tok_q        <= TOK_NONE;
      run_q        <= '0;
      bad_q        <= 1'b0;
      divz_q       <= 1'b0;
      pend_end_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= STAT_OK;
    end else begin
      state_q      <= state_d;
      acc_q        <= acc_d;
      digits_q     <= digits_d;
      tok_q        <= tok_d;
      run_q        <= run_d;
      bad_q        <= bad_d;
      divz_q       <= divz_d;
      pend_end_q   <= pend_end_d;
      out_valid_q  <= out_valid_d;
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
    end
  end

  a_emit_from_emit_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside the emit state");

  a_alu_done_in_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q == ST_EXEC))
    else $error("multiply/divide finished while not waiting for it");

  a_end_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.end_of_expression) |=> (state_q != ST_IDLE))
    else $error("last character did not lead to a result");

  a_status_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.status == STAT_OK || out_o.status == STAT_BAD ||
                     out_o.status == STAT_DIV0))
    else $error("illegal result status");

endmodule

`default_nettype wire

FILE: design/lrexp_alu.sv
// ----------------------------------------------------------------------------
// lrexp_alu
// Iterative multiply / signed divide sharing one add-subtract unit.
// One bit per cycle: shift-add multiply, restoring divide on magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module lrexp_alu #(
  parameter int unsigned WORD_BITS = lrexp_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lrexp_pkg::alu_req_t  req_i,
  input  wire logic [WORD_BITS-1:0] a_i,
  input  wire logic [WORD_BITS-1:0] b_i,
  output logic                      done_o,
  output logic [WORD_BITS-1:0]      result_o
);
  import lrexp_pkg::*;

  localparam int unsigned WB    = WORD_BITS;
  localparam int unsigned CNT_W = $clog2(WB + 1);

  typedef enum logic [1:0] {
    U_IDLE,
    U_RUN,
    U_FIN
  } ustate_e;

  function automatic logic [WB-1:0] negate(input logic [WB-1:0] v);
    negate = ~v + WB'(1);
  endfunction

  ustate_e          state_q, state_d;
  alu_op_e          op_q, op_d;
  logic [WB-1:0]    x_q, x_d;   // product accumulator / remainder
  logic [WB-1:0]    y_q, y_d;   // shifted multiplicand / dividend-quotient
  logic [WB-1:0]    z_q, z_d;   // multiplier / divisor magnitude
  logic             neg_q, neg_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [WB-1:0]    res_q, res_d;

  logic [WB+1:0]    add_x, add_y, sum;
  logic             sub;

  // the one shared adder
  always_comb begin
    if (op_q == ALU_DIV) begin
      sub   = 1'b1;
      add_x = {1'b0, x_q, y_q[WB-1]};
      add_y = {2'b00, z_q};
    end else begin
      sub   = 1'b0;
      add_x = {2'b00, x_q};
      add_y = {2'b00, y_q};
    end
    sum = sub ? (add_x - add_y) : (add_x + add_y);
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    res_d   = res_q;
    unique case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          op_d    = req_i.op;
          x_d     = '0;
          cnt_d   = '0;
          state_d = U_RUN;
          if (req_i.op == ALU_DIV) begin
            y_d   = a_i[WB-1] ? negate(a_i) : a_i;
            z_d   = b_i[WB-1] ? negate(b_i) : b_i;
            neg_d = a_i[WB-1] ^ b_i[WB-1];
          end else begin
            y_d   = a_i;
            z_d   = b_i;
            neg_d = 1'b0;
          end
        end
      end
      U_RUN: begin
        if (op_q == ALU_DIV) begin
          if (!sum[WB+1]) begin
            x_d = sum[WB-1:0];
            y_d = {y_q[WB-2:0], 1'b1};
          end else begin
            x_d = add_x[WB-1:0];
            y_d = {y_q[WB-2:0], 1'b0};
          end
        end else begin
          if (z_q[0]) begin
            x_d = sum[WB-1:0];
          end
          y_d = {y_q[WB-2:0], 1'b0};
          z_d = {1'b0, z_q[WB-1:1]};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(WB - 1)) begin
          state_d = U_FIN;
        end
      end
      U_FIN: begin
        if (op_q == ALU_DIV) begin
          res_d = neg_q ? negate(y_q) : y_q;
        end else begin
          res_d = x_q;
        end
        done_d  = 1'b1;
        state_d = U_IDLE;
      end
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      op_q    <= ALU_MUL;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      neg_q   <= neg_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire
